FILE: rtl/field_subtoken_splitter_top_defines.svh
// ----------------------------------------------------------------------------
// Field sub-token splitter: assertion macros
// Shared property macros for the concurrent checks of the splitter.
// ----------------------------------------------------------------------------
`ifndef FIELD_SUBTOKEN_SPLITTER_TOP_DEFINES_SVH
`define FIELD_SUBTOKEN_SPLITTER_TOP_DEFINES_SVH

// Implication in the same cycle, disabled while reset is asserted.
`define FSS_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Implication checked in the next cycle, disabled while reset is asserted.
`define FSS_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: rtl/fss_pkg.sv
// ----------------------------------------------------------------------------
// Field sub-token splitter package
// Types, constants and per-byte helper functions shared by the splitter.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package fss_pkg;

  localparam int unsigned TOKEN_LIMIT = 32;
  localparam int unsigned TD_W        = $clog2(TOKEN_LIMIT + 1);
  localparam int unsigned NUM_W       = 5;
  localparam int unsigned POS_W       = 16;
  localparam int unsigned VAL_W       = 63;
  localparam int unsigned CFG_IDX_W   = 3;
  localparam int unsigned CFG_DATA_W  = 64;

  localparam logic [POS_W-1:0] FIELD_BYTES_MAX = 16'd65535;
  localparam logic [7:0]       CHAR_ZERO       = 8'h30;
  localparam logic [7:0]       CHAR_NINE       = 8'h39;
  localparam logic [7:0]       CHAR_SPACE      = 8'h20;

  localparam logic [63:0] SEP_RESET_0 = 64'd3170674913811890690;
  localparam logic [63:0] SEP_RESET_1 = 64'd1152921506754330624;
  localparam logic [63:0] SEP_RESET_2 = 64'd0;
  localparam logic [63:0] SEP_RESET_3 = 64'd0;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_SEP_0_63    = 3'd0,
    REG_SEP_64_127  = 3'd1,
    REG_SEP_128_191 = 3'd2,
    REG_SEP_192_255 = 3'd3,
    REG_DIGIT_SPLIT = 3'd4
  } cfg_reg_e;

  typedef struct packed {
    logic [POS_W-1:0] start;
    logic [POS_W-1:0] length;
    logic             starts_digit;
    logic             all_digits;
    logic             overflow;
    logic [VAL_W-1:0] accum;
    logic [POS_W-1:0] zero_run;
  } tok_state_t;

  typedef struct packed {
    logic [NUM_W-1:0] token_number;
    logic [POS_W-1:0] token_start;
    logic [POS_W-1:0] token_length;
    logic [7:0]       separator_byte;
    logic             double_space;
    logic             is_integer;
    logic [VAL_W-1:0] int_value;
    logic [POS_W-1:0] zero_lead_cnt;
    logic             last_token;
  } result_t;

  function automatic logic digit_char(logic [7:0] c);
    return (c >= CHAR_ZERO) && (c <= CHAR_NINE);
  endfunction

  function automatic logic [POS_W-1:0] sat_inc(logic [POS_W-1:0] v);
    return (v < FIELD_BYTES_MAX) ? v + POS_W'(1) : v;
  endfunction

  function automatic tok_state_t tok_clear();
    tok_state_t t;
    t = '0;
    t.all_digits = 1'b1;
    return t;
  endfunction

  // Appends one byte to an open token; the value check works on the exact
  // product so that any excess over the 63-bit range sets the overflow flag.
  function automatic tok_state_t tok_take(tok_state_t t, logic [7:0] c);
    tok_state_t       r;
    logic [67:0]      prod;
    logic [7:0]       dig;
    r    = t;
    dig  = c - CHAR_ZERO;
    prod = ({5'd0, t.accum} << 3) + ({5'd0, t.accum} << 1) + {60'd0, dig};
    if (digit_char(c)) begin
      if (!t.overflow) begin
        if (prod[67:VAL_W] != '0) begin
          r.overflow = 1'b1;
        end else begin
          r.accum = prod[VAL_W-1:0];
        end
      end
    end else begin
      r.all_digits = 1'b0;
    end
    if ((t.zero_run == t.length) && (c == CHAR_ZERO)) begin
      r.zero_run = sat_inc(t.zero_run);
    end
    r.length = sat_inc(t.length);
    return r;
  endfunction

  function automatic tok_state_t tok_open(logic [7:0] c, logic [POS_W-1:0] pos);
    tok_state_t r;
    logic [7:0] dig;
    dig            = c - CHAR_ZERO;
    r.start        = pos;
    r.length       = POS_W'(1);
    r.starts_digit = digit_char(c);
    r.all_digits   = digit_char(c);
    r.overflow     = 1'b0;
    r.accum        = digit_char(c) ? {55'd0, dig} : '0;
    r.zero_run     = (c == CHAR_ZERO) ? POS_W'(1) : '0;
    return r;
  endfunction

  function automatic result_t make_result(tok_state_t t, logic [NUM_W-1:0] num,
                                          logic [7:0] sep, logic dbl, logic last);
    result_t r;
    logic    isint;
    isint            = t.starts_digit && t.all_digits && !t.overflow;
    r.token_number   = num;
    r.token_start    = t.start;
    r.token_length   = t.length;
    r.separator_byte = sep;
    r.double_space   = dbl;
    r.is_integer     = isint;
    r.int_value      = isint ? t.accum : '0;
    r.zero_lead_cnt  = !isint ? '0 :
                       (t.zero_run < t.length) ? t.zero_run : t.length - POS_W'(1);
    r.last_token     = last;
    return r;
  endfunction

endpackage

FILE: rtl/fss_in_if.sv
// ----------------------------------------------------------------------------
// Field sub-token splitter: byte input channel
// Valid/ready channel carrying one field byte and its end-of-field mark.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

interface fss_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       end_of_field;

  modport source (output valid, output data_byte, output end_of_field, input ready);
  modport sink (input valid, input data_byte, input end_of_field, output ready);
endinterface

FILE: rtl/fss_out_if.sv
// ----------------------------------------------------------------------------
// Field sub-token splitter: token result channel
// Valid/ready channel carrying the description of one token.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

interface fss_out_if
  import fss_pkg::*;
;
  logic             valid;
  logic             ready;
  logic [NUM_W-1:0] token_number;
  logic [POS_W-1:0] token_start;
  logic [POS_W-1:0] token_length;
  logic [7:0]       separator_byte;
  logic             double_space;
  logic             is_integer;
  logic [VAL_W-1:0] int_value;
  logic [POS_W-1:0] zero_lead_cnt;
  logic             last_token;

  modport source (output valid, output token_number, output token_start,
                  output token_length, output separator_byte, output double_space,
                  output is_integer, output int_value, output zero_lead_cnt,
                  output last_token, input ready);
  modport sink (input valid, input token_number, input token_start,
                input token_length, input separator_byte, input double_space,
                input is_integer, input int_value, input zero_lead_cnt,
                input last_token, output ready);
endinterface

FILE: rtl/fss_cfg_if.sv
// ----------------------------------------------------------------------------
// Field sub-token splitter: configuration write channel
// Valid/ready channel carrying a register index and its write data.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

interface fss_cfg_if
  import fss_pkg::*;
;
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface

FILE: rtl/field_subtoken_splitter_top.sv
// ----------------------------------------------------------------------------
// Field sub-token splitter
// Splits a header field, one byte per transfer, into tokens and reports
// position, length, separator and decimal value of each token.
// ----------------------------------------------------------------------------
//   Channel  Direction  Transfer contents
//   in_i     input      data_byte, end_of_field
//   out_o    output     one token description
//   cfg_i    input      register index, 64-bit write data
//
// One byte is taken every cycle while the result queue has room; a byte
// is captured in the byte register, and a token it releases is written to
// the result queue when that byte is processed and is then offered on out_o.
// The byte register processes a byte only when the four-entry result queue
// has room for two results, since one byte can release two tokens.
// rst_ni clears the field state, the queue and the separator set to defaults.
// A stalled out_o fills the queue and then holds in_i back.
`timescale 1ns / 1ps
`include "field_subtoken_splitter_top_defines.svh"

module field_subtoken_splitter_top
  import fss_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  fss_in_if.sink    in_i,
  fss_out_if.source out_o,
  fss_cfg_if.sink   cfg_i
);

  localparam int unsigned QDEPTH = 4;
  localparam int unsigned QPTR_W = $clog2(QDEPTH);
  localparam int unsigned QCNT_W = $clog2(QDEPTH + 1);

  logic [3:0][63:0] sep_q;
  logic             dsplit_q;

  logic             in_vq;
  logic [7:0]       in_byte_q;
  logic             in_eof_q;

  logic             held_q, held_d;
  logic             space_q, space_d;
  logic             final_q, final_d;
  logic [TD_W-1:0]  td_q, td_d;
  logic [POS_W-1:0] pos_q, pos_d;
  tok_state_t       tok_q, tok_d;

  result_t          queue_q [QDEPTH];
  logic [QPTR_W-1:0] wr_q, rd_q;
  logic [QCNT_W-1:0] cnt_q;

  logic       proc_fire;
  logic       pop;
  logic       r0_v, r1_v;
  result_t    r0, r1;
  tok_state_t t_open, t_take;
  logic       b_dig, sep_hit, ends, opens;
  logic [NUM_W-1:0] num0, num1;
  logic [QCNT_W-1:0] n_push;

  assign proc_fire = in_vq && (cnt_q <= QCNT_W'(QDEPTH - 2));
  assign in_i.ready = !in_vq || proc_fire;
  assign cfg_i.ready = 1'b1;
  assign pop = out_o.valid && out_o.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sep_q    <= {SEP_RESET_3, SEP_RESET_2, SEP_RESET_1, SEP_RESET_0};
      dsplit_q <= 1'b0;
    end else if (cfg_i.valid && cfg_i.ready) begin
      unique case (cfg_i.index)
        REG_SEP_0_63:    sep_q[0] <= cfg_i.data;
        REG_SEP_64_127:  sep_q[1] <= cfg_i.data;
        REG_SEP_128_191: sep_q[2] <= cfg_i.data;
        REG_SEP_192_255: sep_q[3] <= cfg_i.data;
        REG_DIGIT_SPLIT: dsplit_q <= cfg_i.data[0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vq <= 1'b0;
    end else if (in_i.ready) begin
      in_vq <= in_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_i.valid && in_i.ready) begin
      in_byte_q <= in_i.data_byte;
      in_eof_q  <= in_i.end_of_field;
    end
  end

  always_comb begin
    b_dig   = digit_char(in_byte_q);
    sep_hit = sep_q[in_byte_q[7:6]][in_byte_q[5:0]];
    ends    = !final_q && ((dsplit_q && (tok_q.starts_digit != b_dig)) || sep_hit);
    t_open  = tok_open(in_byte_q, pos_q);
    t_take  = tok_take(tok_q, in_byte_q);
    num0    = td_q[NUM_W-1:0];
    num1    = NUM_W'(td_q + TD_W'(1));

    r0_v    = 1'b0;
    r1_v    = 1'b0;
    r0      = make_result(tok_q, num0, 8'd0, 1'b0, 1'b0);
    r1      = make_result(t_open, num1, 8'd0, 1'b0, 1'b1);
    opens   = 1'b0;
    held_d  = held_q;
    space_d = space_q;
    tok_d   = tok_q;

    priority if (space_q) begin
      r0_v    = 1'b1;
      space_d = 1'b0;
      r0      = make_result(tok_q, num0, CHAR_SPACE, in_byte_q == CHAR_SPACE,
                            (in_byte_q == CHAR_SPACE) && in_eof_q);
      if (in_byte_q == CHAR_SPACE) begin
        held_d = 1'b0;
      end else begin
        opens = 1'b1;
      end
    end else if (held_q) begin
      if (!ends) begin
        tok_d = t_take;
        if (in_eof_q) begin
          r0_v = 1'b1;
          r0   = make_result(t_take, num0, 8'd0, 1'b0, 1'b1);
        end
      end else if (sep_hit && (in_byte_q != 8'd0)) begin
        if ((in_byte_q == CHAR_SPACE) && !in_eof_q) begin
          space_d = 1'b1;
        end else begin
          r0_v   = 1'b1;
          held_d = 1'b0;
          r0     = make_result(tok_q, num0, in_byte_q, 1'b0, in_eof_q);
        end
      end else begin
        r0_v  = 1'b1;
        opens = 1'b1;
      end
    end else begin
      opens = 1'b1;
    end

    if (opens) begin
      tok_d  = t_open;
      held_d = 1'b1;
      if (in_eof_q) begin
        if (r0_v) begin
          r1_v = 1'b1;
        end else begin
          r0_v = 1'b1;
          r0   = make_result(t_open, num0, 8'd0, 1'b0, 1'b1);
        end
      end
    end

    n_push  = QCNT_W'(r0_v) + QCNT_W'(r1_v);
    td_d    = td_q + TD_W'(r0_v) + TD_W'(r1_v);
    final_d = final_q || (td_d >= TD_W'(TOKEN_LIMIT - 1));
    pos_d   = sat_inc(pos_q);

    if (in_eof_q) begin
      held_d  = 1'b0;
      space_d = 1'b0;
      final_d = 1'b0;
      td_d    = '0;
      pos_d   = '0;
      tok_d   = tok_clear();
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      held_q  <= 1'b0;
      space_q <= 1'b0;
      final_q <= 1'b0;
      td_q    <= '0;
      pos_q   <= '0;
      tok_q   <= tok_clear();
    end else if (proc_fire) begin
      held_q  <= held_d;
      space_q <= space_d;
      final_q <= final_d;
      td_q    <= td_d;
      pos_q   <= pos_d;
      tok_q   <= tok_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (proc_fire && r0_v) begin
      queue_q[wr_q] <= r0;
    end
    if (proc_fire && r1_v) begin
      queue_q[QPTR_W'(wr_q + QPTR_W'(1))] <= r1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (proc_fire) begin
        wr_q <= QPTR_W'(wr_q + n_push[QPTR_W-1:0]);
      end
      if (pop) begin
        rd_q <= rd_q + QPTR_W'(1);
      end
      cnt_q <= cnt_q + (proc_fire ? n_push : '0) - QCNT_W'(pop);
    end
  end

  assign out_o.valid          = (cnt_q != '0);
  assign out_o.token_number   = queue_q[rd_q].token_number;
  assign out_o.token_start    = queue_q[rd_q].token_start;
  assign out_o.token_length   = queue_q[rd_q].token_length;
  assign out_o.separator_byte = queue_q[rd_q].separator_byte;
  assign out_o.double_space   = queue_q[rd_q].double_space;
  assign out_o.is_integer     = queue_q[rd_q].is_integer;
  assign out_o.int_value      = queue_q[rd_q].int_value;
  assign out_o.zero_lead_cnt  = queue_q[rd_q].zero_lead_cnt;
  assign out_o.last_token     = queue_q[rd_q].last_token;

  `FSS_ASSERT_NOW(a_queue_bound, 1'b1, cnt_q <= QCNT_W'(QDEPTH), "result queue overfilled")
  `FSS_ASSERT_NOW(a_second_needs_first, proc_fire && r1_v, r0_v, "second token without first")
  `FSS_ASSERT_NOW(a_nonempty_token, proc_fire && r0_v, r0.token_length != '0, "empty token")
  `FSS_ASSERT_NEXT(a_field_cleared, proc_fire && in_eof_q,
                   (td_q == '0) && !held_q && !space_q && (pos_q == '0),
                   "field state not cleared after end of field")
  `FSS_ASSERT_NOW(a_eof_releases, proc_fire && in_eof_q, r0_v, "end of field without a token")

endmodule

FILE: verif/fss_token_checker.sv
// ----------------------------------------------------------------------------
// Field sub-token splitter: token checker
// Watches the byte, token and register channels, works out the tokens that
// each byte transfer releases and compares every token transfer, field by
// field, with the oldest token still expected.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module fss_token_checker
  import fss_pkg::*;
(
  input  logic clk_i,
  input  logic rst_ni,
  fss_in_if    in_i,
  fss_out_if   out_i,
  fss_cfg_if   cfg_i,
  output int   pending_o,
  output int   mismatches_o
);

  localparam logic [63:0] VALUE_MAX = 64'h7FFF_FFFF_FFFF_FFFF;

  logic [63:0]      sep_map [4];
  logic             split_on_class;
  logic             token_open;
  logic             space_wait;
  logic [POS_W-1:0] field_pos;
  logic [POS_W-1:0] tok_start;
  logic [POS_W-1:0] tok_len;
  logic [POS_W-1:0] tok_zeros;
  int unsigned      tok_count;
  logic             tok_digit_first;
  logic             tok_all_digits;
  logic             tok_overflow;
  logic [63:0]      tok_value;
  result_t          token_queue [$];
  int               mismatch_total = 0;

  assign mismatches_o = mismatch_total;

  function automatic logic is_dec_digit(logic [7:0] c);
    return (c >= CHAR_ZERO) && (c <= CHAR_NINE);
  endfunction

  function automatic logic in_sep_set(logic [7:0] c);
    return sep_map[c[7:6]][c[5:0]];
  endfunction

  function automatic logic [POS_W-1:0] bump16(logic [POS_W-1:0] v);
    return (v == '1) ? v : v + POS_W'(1);
  endfunction

  task automatic report_mismatch(input string msg);
    $display("%0t: %s", $time, msg);
    mismatch_total++;
  endtask

  task automatic compare_field(input string what, input logic [63:0] got,
                               input logic [63:0] want, input logic [NUM_W-1:0] num);
    if (got !== want) begin
      report_mismatch($sformatf("token %0d %s: got %0h, expected %0h", num, what, got, want));
    end
  endtask

  task automatic clear_field_state();
    token_open      = 1'b0;
    space_wait      = 1'b0;
    field_pos       = '0;
    tok_start       = '0;
    tok_len         = '0;
    tok_zeros       = '0;
    tok_count       = 0;
    tok_digit_first = 1'b0;
    tok_all_digits  = 1'b1;
    tok_overflow    = 1'b0;
    tok_value       = '0;
  endtask

  task automatic append_byte(input logic [7:0] b);
    logic        in_lead;
    logic [63:0] d;
    in_lead = (tok_zeros == tok_len);
    if (is_dec_digit(b)) begin
      d = 64'(b) - 64'(CHAR_ZERO);
      if (!tok_overflow) begin
        if (tok_value > (VALUE_MAX - d) / 64'd10) begin
          tok_overflow = 1'b1;
        end else begin
          tok_value = tok_value * 64'd10 + d;
        end
      end
    end else begin
      tok_all_digits = 1'b0;
    end
    if (in_lead && (b == CHAR_ZERO)) tok_zeros = bump16(tok_zeros);
    tok_len    = bump16(tok_len);
    token_open = 1'b1;
  endtask

  task automatic release_token(input logic [7:0] sep, input logic dbl, input logic last);
    result_t t;
    logic    whole;
    whole            = tok_digit_first && tok_all_digits && !tok_overflow;
    t.token_number   = NUM_W'(tok_count);
    t.token_start    = tok_start;
    t.token_length   = tok_len;
    t.separator_byte = sep;
    t.double_space   = dbl;
    t.is_integer     = whole;
    t.int_value      = whole ? tok_value[VAL_W-1:0] : '0;
    t.zero_lead_cnt  = !whole ? '0 : (tok_zeros < tok_len) ? tok_zeros : tok_len - POS_W'(1);
    t.last_token     = last;
    token_queue.push_back(t);
    tok_count++;
    token_open = 1'b0;
    space_wait = 1'b0;
  endtask

  task automatic predict_byte(input logic [7:0] b, input logic eof);
    logic [POS_W-1:0] here;
    logic             opens;
    logic             ends;
    logic [7:0]       sep_b;
    here      = field_pos;
    opens     = 1'b1;
    field_pos = bump16(field_pos);
    if (space_wait) begin
      if (b == CHAR_SPACE) begin
        release_token(CHAR_SPACE, 1'b1, eof);
        opens = 1'b0;
      end else begin
        release_token(CHAR_SPACE, 1'b0, 1'b0);
      end
    end else if (token_open) begin
      ends = (tok_count < TOKEN_LIMIT - 1) &&
             ((split_on_class && (tok_digit_first != is_dec_digit(b))) || in_sep_set(b));
      if (!ends) begin
        append_byte(b);
        if (eof) release_token(8'h00, 1'b0, 1'b1);
        opens = 1'b0;
      end else begin
        sep_b = in_sep_set(b) ? b : 8'h00;
        if (sep_b != 8'h00) begin
          opens = 1'b0;
          if ((sep_b == CHAR_SPACE) && !eof) begin
            space_wait = 1'b1;
          end else begin
            release_token(sep_b, 1'b0, eof);
          end
        end else begin
          release_token(8'h00, 1'b0, 1'b0);
        end
      end
    end
    if (opens) begin
      tok_start       = here;
      tok_len         = '0;
      tok_zeros       = '0;
      tok_value       = '0;
      tok_overflow    = 1'b0;
      tok_all_digits  = 1'b1;
      tok_digit_first = is_dec_digit(b);
      append_byte(b);
      if (eof) release_token(8'h00, 1'b0, 1'b1);
    end
    if (eof) clear_field_state();
  endtask

  always @(posedge clk_i or negedge rst_ni) begin : monitor
    result_t want;
    if (!rst_ni) begin
      sep_map[0]     = SEP_RESET_0;
      sep_map[1]     = SEP_RESET_1;
      sep_map[2]     = SEP_RESET_2;
      sep_map[3]     = SEP_RESET_3;
      split_on_class = 1'b0;
      clear_field_state();
      token_queue.delete();
      pending_o <= 0;
    end else begin
      if (cfg_i.valid && cfg_i.ready) begin
        case (cfg_reg_e'(cfg_i.index))
          REG_SEP_0_63:    sep_map[0] = cfg_i.data;
          REG_SEP_64_127:  sep_map[1] = cfg_i.data;
          REG_SEP_128_191: sep_map[2] = cfg_i.data;
          REG_SEP_192_255: sep_map[3] = cfg_i.data;
          REG_DIGIT_SPLIT: split_on_class = cfg_i.data[0];
          default: ;
        endcase
      end
      if (out_i.valid && out_i.ready) begin
        if (token_queue.size() == 0) begin
          report_mismatch($sformatf("token %0d transferred with none expected",
                                    out_i.token_number));
        end else begin
          want = token_queue.pop_front();
          compare_field("number", 64'(out_i.token_number), 64'(want.token_number),
                        want.token_number);
          compare_field("start", 64'(out_i.token_start), 64'(want.token_start),
                        want.token_number);
          compare_field("length", 64'(out_i.token_length), 64'(want.token_length),
                        want.token_number);
          compare_field("separator", 64'(out_i.separator_byte), 64'(want.separator_byte),
                        want.token_number);
          compare_field("double space", 64'(out_i.double_space), 64'(want.double_space),
                        want.token_number);
          compare_field("integer flag", 64'(out_i.is_integer), 64'(want.is_integer),
                        want.token_number);
          compare_field("value", 64'(out_i.int_value), 64'(want.int_value),
                        want.token_number);
          compare_field("leading zeros", 64'(out_i.zero_lead_cnt), 64'(want.zero_lead_cnt),
                        want.token_number);
          compare_field("last", 64'(out_i.last_token), 64'(want.last_token),
                        want.token_number);
        end
      end
      if (in_i.valid && in_i.ready) predict_byte(in_i.data_byte, in_i.end_of_field);
      pending_o <= token_queue.size();
    end
  end

endmodule

FILE: verif/testbench.sv
// ----------------------------------------------------------------------------
// Field sub-token splitter testbench
// Drives header fields byte by byte through a sequence of separator and
// digit-split settings and idling patterns, including a long receiver
// hold-off, while the token checker compares results.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module testbench;
  import fss_pkg::*;

  localparam int HOLD_CYCLES = 300;

  logic clk_i = 1'b0;
  logic rst_ni;

  fss_in_if  in_ch ();
  fss_out_if out_ch ();
  fss_cfg_if cfg_ch ();

  int          pending;
  int          mismatches;
  int          sent_items   = 0;
  int          sender_idle  = 0;
  int          stall_pct    = 0;
  int          holds_asked  = 0;
  int          holds_served = 0;
  int          hold_left    = 0;
  logic [63:0] sep_mirror [4];
  logic [7:0]  field_bytes [$];
  string       huge_nums [3] = '{"9223372036854775807", "9223372036854775808",
                                 "18446744073709551616"};

  field_subtoken_splitter_top dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_ch),
    .out_o  (out_ch),
    .cfg_i  (cfg_ch)
  );

  fss_token_checker checker_inst (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_i         (in_ch),
    .out_i        (out_ch),
    .cfg_i        (cfg_ch),
    .pending_o    (pending),
    .mismatches_o (mismatches)
  );

  always #5 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    if (!rst_ni) begin
      out_ch.ready <= 1'b0;
    end else if (hold_left != 0) begin
      out_ch.ready <= 1'b0;
      hold_left    <= hold_left - 1;
    end else if (holds_served != holds_asked) begin
      out_ch.ready <= 1'b0;
      hold_left    <= HOLD_CYCLES;
      holds_served <= holds_served + 1;
    end else begin
      out_ch.ready <= ($urandom_range(99, 0) >= stall_pct);
    end
  end

  function automatic logic [7:0] pick_separator();
    logic [7:0] c;
    for (int k = 0; k < 24; k++) begin
      c = 8'($urandom_range(255, 0));
      if (sep_mirror[c[7:6]][c[5:0]]) return c;
    end
    return CHAR_SPACE;
  endfunction

  function automatic logic [7:0] noise_byte();
    case ($urandom_range(4, 0))
      0, 1:    return CHAR_ZERO + 8'($urandom_range(9, 0));
      2:       return 8'($urandom_range(255, 0));
      3:       return CHAR_SPACE;
      default: return pick_separator();
    endcase
  endfunction

  task automatic send_byte(input logic [7:0] b, input logic eof);
    while ($urandom_range(99, 0) < sender_idle) begin
      in_ch.valid <= 1'b0;
      @(posedge clk_i);
    end
    in_ch.valid        <= 1'b1;
    in_ch.data_byte    <= b;
    in_ch.end_of_field <= eof;
    do @(posedge clk_i); while (!in_ch.ready);
    sent_items++;
  endtask

  task automatic send_string(input string s);
    for (int i = 0; i < s.len(); i++) send_byte(s[i], i == s.len() - 1);
  endtask

  task automatic write_reg(input cfg_reg_e idx, input logic [63:0] value);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data  <= value;
    do @(posedge clk_i); while (!cfg_ch.ready);
  endtask

  task automatic load_config(input logic [63:0] s0, input logic [63:0] s1,
                             input logic [63:0] s2, input logic [63:0] s3,
                             input logic split);
    write_reg(REG_SEP_0_63, s0);
    write_reg(REG_SEP_64_127, s1);
    write_reg(REG_SEP_128_191, s2);
    write_reg(REG_SEP_192_255, s3);
    write_reg(REG_DIGIT_SPLIT, {63'd0, split});
    cfg_ch.valid <= 1'b0;
    sep_mirror[0] = s0;
    sep_mirror[1] = s1;
    sep_mirror[2] = s2;
    sep_mirror[3] = s3;
  endtask

  task automatic drain();
    in_ch.valid <= 1'b0;
    do @(posedge clk_i); while (pending != 0);
    repeat (10) @(posedge clk_i);
  endtask

  // Mostly well-formed fields of numbers and words joined by separators; a
  // fifth carry 28 to 40 tokens, around the token limit, a fifth are noise.
  task automatic build_field();
    int    style;
    int    ntok;
    int    len;
    int    kind;
    string num;
    field_bytes.delete();
    style = $urandom_range(9, 0);
    if (style < 2) begin
      len = $urandom_range(24, 1);
      repeat (len) field_bytes.push_back(noise_byte());
    end else begin
      ntok = (style < 4) ? $urandom_range(40, 28) : $urandom_range(6, 1);
      for (int t = 0; t < ntok; t++) begin
        if (t != 0) begin
          case ($urandom_range(3, 0))
            0: begin
              field_bytes.push_back(CHAR_SPACE);
              field_bytes.push_back(CHAR_SPACE);
            end
            1:       field_bytes.push_back(CHAR_SPACE);
            default: field_bytes.push_back(pick_separator());
          endcase
        end
        kind = (ntok > 6) ? $urandom_range(1, 0) : $urandom_range(5, 0);
        case (kind)
          0, 4: begin
            if ($urandom_range(2, 0) == 0) begin
              repeat ($urandom_range(4, 1)) field_bytes.push_back(CHAR_ZERO);
            end
            len = (ntok > 6) ? $urandom_range(2, 1) : $urandom_range(22, 1);
            repeat (len) field_bytes.push_back(CHAR_ZERO + 8'($urandom_range(9, 0)));
          end
          1, 5: begin
            len = (ntok > 6) ? $urandom_range(2, 1) : $urandom_range(8, 1);
            repeat (len) field_bytes.push_back(8'h61 + 8'($urandom_range(25, 0)));
          end
          2: begin
            repeat ($urandom_range(4, 1)) field_bytes.push_back(8'($urandom_range(255, 0)));
          end
          default: begin
            num = huge_nums[$urandom_range(2, 0)];
            for (int i = 0; i < num.len(); i++) field_bytes.push_back(num[i]);
          end
        endcase
      end
      if ($urandom_range(9, 0) == 0) field_bytes.push_back(pick_separator());
    end
  endtask

  task automatic run_phase(input logic [63:0] s0, input logic [63:0] s1,
                           input logic [63:0] s2, input logic [63:0] s3,
                           input logic split, input int idle, input int stall,
                           input int n, input bit squeeze);
    int goal;
    load_config(s0, s1, s2, s3, split);
    sender_idle = idle;
    stall_pct  <= stall;
    if (squeeze) holds_asked <= holds_asked + 1;
    goal = sent_items + n;
    while (sent_items < goal) begin
      build_field();
      foreach (field_bytes[i]) send_byte(field_bytes[i], i == field_bytes.size() - 1);
    end
    drain();
  endtask

  initial begin
    rst_ni              = 1'b0;
    in_ch.valid         = 1'b0;
    in_ch.data_byte     = 8'h00;
    in_ch.end_of_field  = 1'b0;
    cfg_ch.valid        = 1'b0;
    cfg_ch.index        = REG_SEP_0_63;
    cfg_ch.data         = '0;
    sep_mirror[0]       = SEP_RESET_0;
    sep_mirror[1]       = SEP_RESET_1;
    sep_mirror[2]       = SEP_RESET_2;
    sep_mirror[3]       = SEP_RESET_3;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;

    send_string("0");
    send_byte(8'h00, 1'b1);
    send_byte(8'hFF, 1'b1);
    send_string("ab  7");
    send_string(" x");
    send_string("x:");
    send_string("x ");
    send_string("x  ");
    send_string("x y");
    send_string("007");
    drain();

    run_phase(SEP_RESET_0, SEP_RESET_1, SEP_RESET_2, SEP_RESET_3, 1'b0, 0, 0, 250, 1'b0);
    run_phase({$urandom, $urandom}, {$urandom, $urandom}, {$urandom, $urandom},
              {$urandom, $urandom}, 1'b1, 58, 0, 250, 1'b0);
    run_phase('1, '1, '1, '1, 1'b0, 0, 58, 150, 1'b0);
    run_phase('0, '0, '0, '0, 1'b1, 9, 9, 150, 1'b0);
    run_phase(SEP_RESET_0, SEP_RESET_1, SEP_RESET_2, SEP_RESET_3, 1'b1, 0, 0, 200, 1'b1);
    run_phase({$urandom, $urandom} | 64'h0000_0001_0000_0001, {$urandom, $urandom},
              {$urandom, $urandom}, {$urandom, $urandom}, 1'b0, 58, 58, 250, 1'b1);

    repeat (10) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("Mismatches found");
    $finish;
  end

endmodule
